// File: hw/rtl/name_string_char_class_validator_core_macros.svh
// Assertion macros shared by the validator's checker.
`ifndef NAME_STRING_CHAR_CLASS_VALIDATOR_CORE_MACROS_SVH
`define NAME_STRING_CHAR_CLASS_VALIDATOR_CORE_MACROS_SVH

// A property checked at every rising clock edge outside reset.
`define NSCCV_ASSERT(lbl, clock, resetn, prop) \
    lbl: assert property (@(posedge clock) disable iff (!resetn) prop) \
        else $error("validator assertion failed");

// A condition that must hold whenever the result channel shows a beat.
`define NSCCV_ASSERT_OUT(lbl, clock, resetn, vld, cond) \
    `NSCCV_ASSERT(lbl, clock, resetn, (vld |-> (cond)))

`endif

// File: hw/rtl/nsccv_pkg.sv
// Types, codes and the character classifier of the name string validator.
`default_nettype none

package nsccv_pkg;

    // Longest string length the block distinguishes.
    localparam int MAX_LEN = 255;

    // Count saturation point, never above what nine bits hold.
    localparam int SAT_LIMIT_I = (MAX_LEN + 1 > 511) ? 511 : MAX_LEN + 1;
    localparam logic [8:0] SAT_LIMIT = 9'(SAT_LIMIT_I);
    localparam logic [16:0] MAX_LEN_V = 17'(MAX_LEN);

    typedef logic [3:0] cls_t;
    typedef logic [2:0] status_t;
    typedef logic [1:0] cfg_idx_t;

    localparam cls_t CLS_ENGLISH    = 4'd0;
    localparam cls_t CLS_UNDERSCORE = 4'd1;
    localparam cls_t CLS_SPACE      = 4'd2;
    localparam cls_t CLS_PUNCT_A    = 4'd3;
    localparam cls_t CLS_PUNCT_B    = 4'd4;
    localparam cls_t CLS_HANGUL     = 4'd5;
    localparam cls_t CLS_CJK        = 4'd6;
    localparam cls_t CLS_THAI       = 4'd7;
    localparam cls_t CLS_NONE       = 4'd8;

    localparam status_t STATUS_OK        = 3'd0;
    localparam status_t STATUS_EMPTY     = 3'd1;
    localparam status_t STATUS_TOO_SHORT = 3'd2;
    localparam status_t STATUS_TOO_LONG  = 3'd3;
    localparam status_t STATUS_BAD_CHAR  = 3'd4;

    localparam cfg_idx_t REG_MIN_LENGTH      = 2'd0;
    localparam cfg_idx_t REG_MAX_LENGTH      = 2'd1;
    localparam cfg_idx_t REG_ALLOWED_CLASSES = 2'd2;
    localparam cfg_idx_t REG_CHECK_CLASSES   = 2'd3;

    // Places a code point in its class; earlier tests take priority.
    function automatic cls_t classify(input logic [20:0] c);
        cls_t r;
        if (c inside {[21'h61:21'h7A], [21'h41:21'h5A], [21'h30:21'h39]})
        begin
            r = CLS_ENGLISH;
        end
        else if (c == 21'h5F)
        begin
            r = CLS_UNDERSCORE;
        end
        else if (c == 21'h20)
        begin
            r = CLS_SPACE;
        end
        else if (c inside {21'h2B, 21'h2A, 21'h2E, 21'h7E, 21'h40})
        begin
            r = CLS_PUNCT_A;
        end
        else if (c inside {[21'h21:21'h2F], [21'h3A:21'h40], [21'h5B:21'h60],
                           [21'h7B:21'h7E]})
        begin
            r = CLS_PUNCT_B;
        end
        else if (c inside {[21'hAC00:21'hD7A3]})
        begin
            r = CLS_HANGUL;
        end
        else if (c inside {[21'h3000:21'h303F], [21'h3105:21'h312B],
                           [21'h31C0:21'h31EF], [21'h3300:21'h33FF],
                           [21'h3400:21'h4DBF], [21'h4E00:21'h9FFF],
                           [21'hF900:21'hFAFF], [21'hFE30:21'hFE4F],
                           [21'h20000:21'h2A6DF], [21'h2F800:21'h2FA1F],
                           21'h02C7, 21'h02CA, 21'h02CB, 21'h02D9,
                           [21'hFF00:21'hFF26], [21'hFF28:21'hFF2C],
                           [21'hFF2E:21'hFFFF], 21'h2191, 21'h2295,
                           [21'h00:21'h2F], [21'h3A:21'h40],
                           [21'h5B:21'h60], [21'h7B:21'h7F]})
        begin
            r = CLS_CJK;
        end
        else if (c inside {[21'h0E00:21'h0E7F]})
        begin
            r = CLS_THAI;
        end
        else
        begin
            r = CLS_NONE;
        end
        return r;
    endfunction

    // Thai consonants, the only Thai characters allowed to open a string.
    function automatic logic is_thai_consonant(input logic [20:0] c);
        return (c inside {[21'h0E01:21'h0E2E]});
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/name_string_char_class_validator_core.sv
// Top level of the name string character-class validator.
//
// The block receives a string as a stream of Unicode code points, one per input
// beat, and returns one result beat (status and character count) for the beat
// that carries last_char, or for a beat that carries empty_string. Beats without
// either mark return nothing. A new input beat is taken every cycle while the
// result side keeps up. Each beat is captured in the input register, and while it
// sits there the classification, length and class checks run straight into the
// result register, which loads at the clock edge where the beat moves on. The
// one-stage classifier sets that rate; a result left waiting stalls only items that
// would replace it, while ordinary characters still pass.
// Status: 0 ok, 1 empty, 2 too short, 3 too long, 4 disallowed character; length
// is checked before the class checks. The count saturates at MAX_LEN + 1.
// Configuration writes complete at once and should be made only while idle.
`default_nettype none

module name_string_char_class_validator_core
    import nsccv_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration write channel.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire cfg_idx_t    cfg_index,
    input  wire logic [8:0]  cfg_data,
    // Character input channel.
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [20:0] code_point,
    input  wire logic        last_char,
    input  wire logic        empty_string,
    // Result channel.
    output logic             out_valid,
    input  wire logic        out_ready,
    output status_t          status,
    output logic [8:0]       char_count
);

    // Configuration registers.
    logic [7:0] min_length_reg;
    logic [7:0] max_length_reg;
    logic [8:0] allowed_classes_reg;
    logic       check_classes_reg;

    // Input register: one character beat waiting to be classified.
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [20:0] s1_cp_reg;
    logic        s1_last_reg;
    logic        s1_empty_reg;

    // Per-string state.
    logic [8:0] len_reg;
    logic [8:0] len_next;
    logic       fail_reg;
    logic       fail_next;
    logic       first_reg;
    logic       first_next;

    // Result register.
    logic       out_valid_reg;
    logic       out_valid_next;
    status_t    status_reg;
    status_t    status_next;
    logic [8:0] count_reg;
    logic [8:0] count_next;

    logic       advance;
    logic       produce;
    logic       in_fire;
    cls_t       cls;
    logic       char_fail;
    logic [8:0] cnt_inc;
    logic       fail_acc;
    logic       too_short;
    logic       too_long;

    // The configuration port never stalls.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_length_reg      <= 8'd0;
            max_length_reg      <= 8'd255;
            allowed_classes_reg <= 9'h1FF;
            check_classes_reg   <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MIN_LENGTH:      min_length_reg      <= cfg_data[7:0];
                REG_MAX_LENGTH:      max_length_reg      <= cfg_data[7:0];
                REG_ALLOWED_CLASSES: allowed_classes_reg <= cfg_data;
                REG_CHECK_CLASSES:   check_classes_reg   <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    // The stage moves on when its beat gives no result, or when the result
    // register is free or being emptied in this cycle.
    assign advance = s1_valid_reg
                   && (!out_valid_reg || out_ready || (!s1_last_reg && !s1_empty_reg));
    assign produce  = advance && (s1_last_reg || s1_empty_reg);
    assign in_ready = !s1_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    // Classification and the per-character checks.
    assign cls       = classify(s1_cp_reg);
    assign char_fail = check_classes_reg
                     && (!allowed_classes_reg[cls]
                         || (first_reg && (cls == CLS_THAI)
                             && !is_thai_consonant(s1_cp_reg)));
    assign cnt_inc   = (len_reg < SAT_LIMIT) ? len_reg + 9'd1 : len_reg;
    assign fail_acc  = fail_reg || char_fail;

    // Length checks against the count including this character.
    assign too_short = cnt_inc < {1'b0, min_length_reg};
    assign too_long  = (cnt_inc > {1'b0, max_length_reg}) || ({8'd0, cnt_inc} > MAX_LEN_V);

    always_comb
    begin
        len_next    = len_reg;
        fail_next   = fail_reg;
        first_next  = first_reg;
        status_next = status_reg;
        count_next  = count_reg;
        if (advance)
        begin
            if (s1_empty_reg)
            begin
                // An empty string drops whatever was partly received.
                len_next    = 9'd0;
                fail_next   = 1'b0;
                first_next  = 1'b1;
                status_next = (min_length_reg == 8'd0) ? STATUS_OK : STATUS_EMPTY;
                count_next  = 9'd0;
            end
            else if (s1_last_reg)
            begin
                len_next   = 9'd0;
                fail_next  = 1'b0;
                first_next = 1'b1;
                count_next = cnt_inc;
                if (too_short)
                begin
                    status_next = STATUS_TOO_SHORT;
                end
                else if (too_long)
                begin
                    status_next = STATUS_TOO_LONG;
                end
                else if (fail_acc)
                begin
                    status_next = STATUS_BAD_CHAR;
                end
                else
                begin
                    status_next = STATUS_OK;
                end
            end
            else
            begin
                len_next   = cnt_inc;
                fail_next  = fail_acc;
                first_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        if (produce)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_comb
    begin
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            len_reg       <= 9'd0;
            fail_reg      <= 1'b0;
            first_reg     <= 1'b1;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            len_reg       <= len_next;
            fail_reg      <= fail_next;
            first_reg     <= first_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_cp_reg    <= code_point;
            s1_last_reg  <= last_char;
            s1_empty_reg <= empty_string;
        end
        status_reg <= status_next;
        count_reg  <= count_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign char_count = count_reg;

endmodule

`default_nettype wire

// File: hw/rtl/nsccv_chk.sv
// Port-level checker for the validator, bound to its top level.
`default_nettype none

`include "name_string_char_class_validator_core_macros.svh"

module nsccv_chk
    import nsccv_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire status_t    status,
    input wire logic [8:0] char_count
);

    // A stalled result beat keeps its payload.
    `NSCCV_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready |=> out_valid && $stable(status) && $stable(char_count)))

    // Only the five defined status codes are ever shown.
    `NSCCV_ASSERT_OUT(a_status_code, clk, rst_n, out_valid, (status <= STATUS_BAD_CHAR))

    // A count of zero can only come from an empty string.
    `NSCCV_ASSERT_OUT(a_zero_count, clk, rst_n, out_valid, ((char_count != 9'd0) || (status == STATUS_OK) || (status == STATUS_EMPTY)))

    // The count never passes its saturation point.
    `NSCCV_ASSERT_OUT(a_count_sat, clk, rst_n, out_valid, (char_count <= SAT_LIMIT))

endmodule

bind name_string_char_class_validator_core nsccv_chk u_nsccv_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .char_count (char_count)
);

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for the name string character-class validator core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import nsccv_pkg::*;

    // The run is cut off here if the block stops making progress.
    localparam int CYCLE_LIMIT = 400000;
    // Settings phases after the directed part, and the characters sent in each one.
    localparam int PHASES = 12;
    localparam int ITEMS_PER_PHASE = 20;
    // Cycles allowed after the last result.
    localparam int DRAIN_CYCLES = 4;

    // One finished string as the block should report it.
    typedef struct packed {
        status_t    st;
        logic [8:0] cnt;
    } verdict_t;

    // Tracks the validator's settings and the string in progress. It works out the
    // verdict of every finished string and compares the block's results with them.
    class name_check_board;
        logic [7:0] min_len;
        logic [7:0] max_len;
        logic [8:0] class_mask;
        logic       class_check;
        int         run_len;
        bit         flagged;
        bit         opening;
        int         count_cap;
        verdict_t   verdicts_due[$];
        int         mismatches;

        function new();
            min_len = 8'd0;
            max_len = 8'd255;
            class_mask = 9'h1FF;
            class_check = 1'b1;
            count_cap = (MAX_LEN + 1 > 511) ? 511 : MAX_LEN + 1;
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            run_len = 0;
            flagged = 1'b0;
            opening = 1'b1;
        endfunction

        function bit spans(logic [20:0] c, int lo, int hi);
            return (c >= lo) && (c <= hi);
        endfunction

        // Class of one code point. The tests are tried in order and the first match wins.
        function cls_t char_class(logic [20:0] c);
            if (spans(c, 'h61, 'h7A) || spans(c, 'h41, 'h5A) || spans(c, 'h30, 'h39))
                return CLS_ENGLISH;
            if (c == 'h5F)
                return CLS_UNDERSCORE;
            if (c == 'h20)
                return CLS_SPACE;
            if (c == 'h2B || c == 'h2A || c == 'h2E || c == 'h7E || c == 'h40)
                return CLS_PUNCT_A;
            if (spans(c, 'h21, 'h2F) || spans(c, 'h3A, 'h40) || spans(c, 'h5B, 'h60) ||
                spans(c, 'h7B, 'h7E))
                return CLS_PUNCT_B;
            if (spans(c, 'hAC00, 'hD7A3))
                return CLS_HANGUL;
            if (spans(c, 'h3000, 'h303F) || spans(c, 'h3105, 'h312B) ||
                spans(c, 'h31C0, 'h31EF) || spans(c, 'h3300, 'h33FF) ||
                spans(c, 'h3400, 'h4DBF) || spans(c, 'h4E00, 'h9FFF) ||
                spans(c, 'hF900, 'hFAFF) || spans(c, 'hFE30, 'hFE4F) ||
                spans(c, 'h20000, 'h2A6DF) || spans(c, 'h2F800, 'h2FA1F) ||
                c == 'h02C7 || c == 'h02CA || c == 'h02CB || c == 'h02D9 ||
                spans(c, 'hFF00, 'hFF26) || spans(c, 'hFF28, 'hFF2C) ||
                spans(c, 'hFF2E, 'hFFFF) || c == 'h2191 || c == 'h2295 ||
                spans(c, 'h00, 'h2F) || spans(c, 'h3A, 'h40) ||
                spans(c, 'h5B, 'h60) || spans(c, 'h7B, 'h7F))
                return CLS_CJK;
            if (spans(c, 'h0E00, 'h0E7F))
                return CLS_THAI;
            return CLS_NONE;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [8:0] data);
            case (idx)
                REG_MIN_LENGTH:      min_len = data[7:0];
                REG_MAX_LENGTH:      max_len = data[7:0];
                REG_ALLOWED_CLASSES: class_mask = data;
                REG_CHECK_CLASSES:   class_check = data[0];
                default: ;
            endcase
        endfunction

        // Notes one accepted input beat and queues a verdict if it ends a string.
        function void take_char(logic [20:0] cp, logic last, logic empty);
            verdict_t v;
            cls_t     k;
            int       eff_max;
            if (empty)
            begin
                v.st = (min_len == 8'd0) ? STATUS_OK : STATUS_EMPTY;
                v.cnt = 9'd0;
                verdicts_due.push_back(v);
                restart();
                return;
            end
            if (run_len < count_cap)
                run_len++;
            if (class_check)
            begin
                k = char_class(cp);
                if (!class_mask[k])
                    flagged = 1'b1;
                if (opening && k == CLS_THAI && !spans(cp, 'h0E01, 'h0E2E))
                    flagged = 1'b1;
            end
            opening = 1'b0;
            if (!last)
                return;
            eff_max = (max_len < MAX_LEN) ? int'(max_len) : MAX_LEN;
            if (run_len < min_len)
                v.st = STATUS_TOO_SHORT;
            else if (run_len > eff_max)
                v.st = STATUS_TOO_LONG;
            else if (flagged)
                v.st = STATUS_BAD_CHAR;
            else
                v.st = STATUS_OK;
            v.cnt = 9'(run_len);
            verdicts_due.push_back(v);
            restart();
        endfunction

        function void note_mismatch(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] %s", $time, msg);
        endfunction

        // Compares one result beat with the oldest verdict still due.
        function void match_verdict(status_t st, logic [8:0] cnt);
            verdict_t want;
            if (verdicts_due.size() == 0)
            begin
                note_mismatch($sformatf("result with nothing due: status %0d count %0d",
                                        st, cnt));
                return;
            end
            want = verdicts_due.pop_front();
            if (st !== want.st || cnt !== want.cnt)
                note_mismatch($sformatf("expected status %0d count %0d, got status %0d count %0d",
                                        want.st, want.cnt, st, cnt));
        endfunction

        function int outstanding();
            return verdicts_due.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    cfg_idx_t   cfg_index = REG_MIN_LENGTH;
    logic [8:0] cfg_data = 9'd0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [20:0] code_point = 21'd0;
    logic       last_char = 1'b0;
    logic       empty_string = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    status_t    status;
    logic [8:0] char_count;

    // Idling, as a percentage of cycles, for the two sides. The main sequence changes
    // these from phase to phase.
    int in_gap_pct = 18;
    int out_stall_pct = 61;
    int items_sent = 0;
    int cycle_count = 0;

    name_check_board board = new();

    name_string_char_class_validator_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .code_point   (code_point),
        .last_char    (last_char),
        .empty_string (empty_string),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .char_count   (char_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The receiver stalls at random. Each decision is made once per clock edge.
    initial
    begin
        forever
        begin
            @(posedge clk);
            out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
        end
    end

    // All three channels are sampled at the clock edge. The testbench drives its inputs
    // with nonblocking assignments, so the values seen here are the ones the block saw.
    // Settings writes happen only while the block is idle, so the order of the checks
    // below does not matter.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                board.set_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
                board.take_char(code_point, last_char, empty_string);
            if (out_valid && out_ready)
                board.match_verdict(status, char_count);
        end
    end

    // Watchdog. If the count reaches the limit, the run has stalled.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // A code point picked across all the classes, their boundaries and the whole
    // 21-bit field. Thai and plain letters are weighted up, because the first-character
    // rule and most of the ordinary strings depend on them.
    function automatic logic [20:0] random_char();
        logic [31:0] c;
        case ($urandom_range(0, 15))
            0, 1, 12:
                case ($urandom_range(0, 2))
                    0:       c = $urandom_range('h61, 'h7A);
                    1:       c = $urandom_range('h41, 'h5A);
                    default: c = $urandom_range('h30, 'h39);
                endcase
            2: c = 'h5F;
            3: c = 'h20;
            4:
                case ($urandom_range(0, 4))
                    0:       c = 'h2B;
                    1:       c = 'h2A;
                    2:       c = 'h2E;
                    3:       c = 'h7E;
                    default: c = 'h40;
                endcase
            5:
                case ($urandom_range(0, 3))
                    0:       c = $urandom_range('h21, 'h2F);
                    1:       c = $urandom_range('h3A, 'h40);
                    2:       c = $urandom_range('h5B, 'h60);
                    default: c = $urandom_range('h7B, 'h7E);
                endcase
            6: c = $urandom_range('hAC00, 'hD7A3);
            7:
                case ($urandom_range(0, 9))
                    0:       c = $urandom_range('h00, 'h1F);
                    1:       c = 'h7F;
                    2:       c = $urandom_range('h4E00, 'h9FFF);
                    3:       c = $urandom_range('h20000, 'h2A6DF);
                    4:       c = $urandom_range('hFF00, 'hFFFF);
                    5:       c = $urandom_range('h3000, 'h33FF);
                    6:       c = 'h02C7;
                    7:       c = 'h02D9;
                    8:       c = 'h2191;
                    default: c = 'h2295;
                endcase
            8, 9, 13: c = $urandom_range('h0E00, 'h0E7F);
            10:
                case ($urandom_range(0, 15))
                    0:       c = 'h0E00;
                    1:       c = 'h0E01;
                    2:       c = 'h0E2E;
                    3:       c = 'h0E2F;
                    4:       c = 'h0E7F;
                    5:       c = 'h0E80;
                    6:       c = 'hABFF;
                    7:       c = 'hAC00;
                    8:       c = 'hD7A3;
                    9:       c = 'hD7A4;
                    10:      c = 'hFF26;
                    11:      c = 'hFF27;
                    12:      c = 'hFF2D;
                    13:      c = 'h10FFFF;
                    14:      c = 'h110000;
                    default: c = 'h1FFFFF;
                endcase
            11: c = $urandom_range(0, 'h1FFFFF);
            default: c = $urandom_range('h80, 'h2FFF);
        endcase
        return c[20:0];
    endfunction

    // Presents one beat and holds it until it is taken. In a gap, valid is lowered for
    // a whole cycle. It is never lowered and raised at the same edge.
    task automatic send_item(input logic [20:0] cp, input logic last, input logic empty);
        while ($urandom_range(0, 99) < in_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        code_point <= cp;
        last_char <= last;
        empty_string <= empty;
        items_sent++;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Sends a string of len characters. A broken string is cut short at a random point
    // by an empty-string beat, which drops the part already sent.
    task automatic send_word(input int len, input bit broken);
        int cut;
        cut = broken ? $urandom_range(0, len - 1) : len;
        for (int i = 0; i < len; i++)
        begin
            if (i == cut)
            begin
                send_item(random_char(), 1'($urandom_range(0, 1)), 1'b1);
                return;
            end
            send_item(random_char(), i == len - 1, 1'b0);
        end
    endtask

    task automatic cfg_put(input cfg_idx_t idx, input logic [8:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic apply_settings(input logic [7:0] lo, input logic [7:0] hi,
                                  input logic [8:0] mask, input logic chk);
        cfg_put(REG_MIN_LENGTH, {1'b0, lo});
        cfg_put(REG_MAX_LENGTH, {1'b0, hi});
        cfg_put(REG_ALLOWED_CLASSES, mask);
        cfg_put(REG_CHECK_CLASSES, {8'd0, chk});
        cfg_valid <= 1'b0;
    endtask

    // Stops sending and waits until every verdict has been matched. It then lets the
    // pipeline run empty. The first edge lets the monitor note the final beat before
    // the queue is checked.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int goal;
        int roll;
        int len;
        logic [7:0] lo;
        logic [7:0] hi;
        logic [8:0] mask;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed strings under the reset settings: every class is allowed and the
        // class checks are on.
        send_item(21'h1FFFFF, 1'b1, 1'b1);   // empty string passes while min is zero
        send_item(21'h61, 1'b1, 1'b0);       // single letter
        send_item(21'h0E00, 1'b1, 1'b0);     // Thai opening on a non-consonant
        send_item(21'h0E01, 1'b0, 1'b0);     // Thai consonant, then a vowel mark
        send_item(21'h0E30, 1'b1, 1'b0);
        send_item(21'h0E2E, 1'b1, 1'b0);     // last Thai consonant
        send_item(21'h0E2F, 1'b1, 1'b0);     // first Thai code after the consonants
        send_item(21'h1FFFFF, 1'b1, 1'b0);   // beyond the Unicode range
        send_item(21'h110000, 1'b1, 1'b0);
        send_item(21'h62, 1'b0, 1'b0);       // partial string dropped by an empty beat
        send_item(21'h63, 1'b0, 1'b0);
        send_item(21'h000000, 1'b0, 1'b1);
        send_item(21'h64, 1'b1, 1'b0);       // must count as a fresh first character
        send_item(21'h78, 1'b0, 1'b0);       // Thai non-consonant past the first place
        send_item(21'h0E00, 1'b1, 1'b0);
        settle();

        // A minimum length turns an empty string into an error and makes short strings
        // fail.
        apply_settings(8'd2, 8'd255, 9'h1FF, 1'b1);
        send_item(21'h41, 1'b1, 1'b1);
        send_item(21'h41, 1'b1, 1'b0);
        settle();

        // With the class checks off, even an empty mask and a bad Thai opening pass.
        apply_settings(8'd0, 8'd255, 9'h000, 1'b0);
        send_item(21'h0E00, 1'b1, 1'b0);
        send_item(21'h5F, 1'b1, 1'b0);
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            // The sender is light and the receiver heavy, then the other way round,
            // then neither idles.
            if (p < PHASES / 3)
            begin
                in_gap_pct = 18;
                out_stall_pct = 61;
            end
            else if (p < 2 * PHASES / 3)
            begin
                in_gap_pct = 61;
                out_stall_pct = 18;
            end
            else
            begin
                in_gap_pct = 0;
                out_stall_pct = 0;
            end

            case ($urandom_range(0, 9))
                0:       lo = 8'd0;
                1:       lo = 8'd255;
                default: lo = 8'($urandom_range(0, 10));
            endcase
            case ($urandom_range(0, 9))
                0:       hi = 8'd0;
                1, 2:    hi = 8'd255;
                default: hi = 8'($urandom_range(0, 16));
            endcase
            case ($urandom_range(0, 9))
                0:       mask = 9'h1FF;
                1:       mask = 9'd1 << $urandom_range(0, 8);
                2:       mask = 9'h000;
                default: mask = 9'($urandom_range(0, 511));
            endcase

            // The first phases pin the settings to their extremes.
            if (p == 0)
                apply_settings(8'd0, 8'd0, 9'h000, 1'b1);
            else if (p == 1)
                apply_settings(8'd255, 8'd255, 9'h1FF, 1'b0);
            else if (p == 2)
                apply_settings(8'd1, 8'd255, mask, 1'b1);
            else
                apply_settings(lo, hi, mask, $urandom_range(0, 3) != 0);

            // A string that runs the count into saturation.
            if (p == 1)
                send_word(257, 1'b0);

            goal = items_sent + ITEMS_PER_PHASE;
            while (items_sent < goal)
            begin
                roll = $urandom_range(0, 99);
                case ($urandom_range(0, 9))
                    0:       len = 1;
                    1:       len = $urandom_range(9, 20);
                    default: len = $urandom_range(1, 8);
                endcase
                if (roll < 6)
                    send_item(random_char(), 1'($urandom_range(0, 1)), 1'b1);
                else
                    send_word(len, roll < 14);
            end
            settle();
        end

        if (board.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
